>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker module of this project.
// Each macro expects clk and rst_n to be visible in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, disabled while reset is asserted.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication into the next cycle, disabled while reset is asserted.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Holds in the cycle after every cycle with reset asserted.
`define ASSERT_AFTER_RESET(label, cons) \
  label: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/ptio_pkg.sv
// Package for the programmable timer and I/O port: command, register and
// timer mode codes, plus small helper functions. No dependencies.
package ptio_pkg;

  localparam logic [2:0] CMD_READ  = 3'd0;
  localparam logic [2:0] CMD_WRITE = 3'd1;
  localparam logic [2:0] CMD_TICK  = 3'd2;
  localparam logic [2:0] CMD_CP1   = 3'd3;
  localparam logic [2:0] CMD_CP2   = 3'd4;

  localparam logic [2:0] REG_STATUS     = 3'd0;
  localparam logic [2:0] REG_PERIPH     = 3'd1;
  localparam logic [2:0] REG_DIR        = 3'd2;
  localparam logic [2:0] REG_PORT       = 3'd3;
  localparam logic [2:0] REG_STATUS_ALT = 3'd4;
  localparam logic [2:0] REG_TIMER_CTRL = 3'd5;
  localparam logic [2:0] REG_CNT_HIGH   = 3'd6;
  localparam logic [2:0] REG_CNT_LOW    = 3'd7;

  // Timer mode field, bits 5:3 of the timer control register.
  localparam logic [2:0] MODE_CONT_A  = 3'd0;
  localparam logic [2:0] MODE_CONT_B  = 3'd2;
  localparam logic [2:0] MODE_SINGLE  = 3'd4;
  localparam logic [2:0] MODE_CASCADE = 3'd6;

  localparam int TICK_W  = 20;
  localparam int PULSE_W = 4;

  // Recompute the composite interrupt flag in status bit 7.
  function automatic logic [7:0] irq_calc(logic [7:0] st, logic [7:0] tc,
                                          logic [7:0] pc);
    logic c;
    c = (st[0] & tc[6]) | (st[1] & pc[0]) | (st[2] & pc[3] & ~pc[5]);
    return {c, st[6:0]};
  endfunction

  // Tick count for one period: factor * (base + 1), factor 8 or 1.
  function automatic logic [TICK_W-1:0] ticks_calc(logic [15:0] base, logic div8);
    logic [TICK_W-1:0] ext;
    ext = TICK_W'(base) + TICK_W'(1);
    return div8 ? {ext[TICK_W-4:0], 3'b000} : ext;
  endfunction

endpackage

>>> hw/rtl/programmable_timer_io_port.sv
// Top level of the programmable timer and I/O port.
// Depends on ptio_pkg.
//
// One item is accepted per clock cycle. An input register holds the item, and the whole
// register, timer and flag update is done in one pass of logic. A result register then
// presents the outputs. Input is refused only when both registers are full and the
// result side stalls.
module programmable_timer_io_port
  import ptio_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_cmd,
  input  logic [2:0] in_reg_addr,
  input  logic [7:0] in_value,
  input  logic [7:0] in_pins_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data,
  output logic       out_irq_out,
  output logic       out_timer_out,
  output logic [7:0] out_port_drive,
  output logic       out_cp2_drive
);

  // Input register.
  logic       s0_valid_r;
  logic [2:0] s0_cmd_r;
  logic [2:0] s0_addr_r;
  logic [7:0] s0_value_r;
  logic [7:0] s0_pins_r;

  // Block state.
  logic [7:0]         status_r, periph_ctrl_r, dir_mask_r, port_latch_r, timer_ctrl_r;
  logic               cp1_level_r, cp2_level_r, cp2_out_r, raw_tout_r, running_r;
  logic [7:0]         high_buf_r;
  logic [2:0]         pend_clr_r;
  logic [15:0]        reload_r, preset_r;
  logic [TICK_W-1:0]  ticks_r;
  logic [PULSE_W-1:0] pulse_r;

  logic [7:0]         status_nxt, periph_ctrl_nxt, dir_mask_nxt, port_latch_nxt;
  logic [7:0]         timer_ctrl_nxt;
  logic               cp1_level_nxt, cp2_level_nxt, cp2_out_nxt, raw_tout_nxt;
  logic               running_nxt;
  logic [7:0]         high_buf_nxt;
  logic [2:0]         pend_clr_nxt;
  logic [15:0]        reload_nxt, preset_nxt;
  logic [TICK_W-1:0]  ticks_nxt;
  logic [PULSE_W-1:0] pulse_nxt;
  logic [7:0]         rd_nxt;

  // Result register.
  logic       out_valid_r;
  logic [7:0] rd_r;
  logic       irq_r, tout_r, cp2_r;
  logic [7:0] drive_r;

  logic       move;
  logic       do_launch, do_expire, lv;
  logic [2:0] mode;
  logic [15:0] cnt;

  assign move     = s0_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s0_valid_r || move;

  always_comb begin
    status_nxt      = status_r;
    periph_ctrl_nxt = periph_ctrl_r;
    dir_mask_nxt    = dir_mask_r;
    port_latch_nxt  = port_latch_r;
    timer_ctrl_nxt  = timer_ctrl_r;
    cp1_level_nxt   = cp1_level_r;
    cp2_level_nxt   = cp2_level_r;
    cp2_out_nxt     = cp2_out_r;
    raw_tout_nxt    = raw_tout_r;
    running_nxt     = running_r;
    high_buf_nxt    = high_buf_r;
    pend_clr_nxt    = pend_clr_r;
    reload_nxt      = reload_r;
    preset_nxt      = preset_r;
    ticks_nxt       = ticks_r;
    pulse_nxt       = pulse_r;
    rd_nxt          = 8'h00;
    do_launch       = 1'b0;
    do_expire       = 1'b0;
    lv              = |s0_value_r;
    cnt = running_r ? (timer_ctrl_r[2] ? ticks_r[18:3] : ticks_r[15:0]) : preset_r;

    unique case (s0_cmd_r)
      CMD_READ: begin
        unique case (s0_addr_r) inside
          REG_STATUS, REG_STATUS_ALT: begin
            pend_clr_nxt = status_r[2:0];
            rd_nxt       = status_r;
          end
          REG_PERIPH: rd_nxt = periph_ctrl_r;
          REG_DIR:    rd_nxt = dir_mask_r;
          REG_PORT: begin
            if (!periph_ctrl_r[7]) begin
              status_nxt   = irq_calc(status_r & ~{5'b0, pend_clr_r[2:1], 1'b0},
                                      timer_ctrl_r, periph_ctrl_r);
              pend_clr_nxt = {2'b00, pend_clr_r[0]};
            end
            rd_nxt = (port_latch_r & dir_mask_r) | (s0_pins_r & ~dir_mask_r);
          end
          REG_TIMER_CTRL: rd_nxt = timer_ctrl_r;
          REG_CNT_HIGH, REG_CNT_LOW: begin
            if (pend_clr_r[0]) begin
              status_nxt = irq_calc({status_r[7:1], 1'b0}, timer_ctrl_r, periph_ctrl_r);
            end
            pend_clr_nxt = {pend_clr_r[2:1], 1'b0};
            rd_nxt = (s0_addr_r == REG_CNT_HIGH) ? cnt[15:8] : cnt[7:0];
          end
          default: rd_nxt = 8'h00;
        endcase
      end
      CMD_WRITE: begin
        unique case (s0_addr_r)
          REG_PERIPH: begin
            periph_ctrl_nxt = s0_value_r;
            if (s0_value_r[7]) begin
              port_latch_nxt = 8'h00;
              dir_mask_nxt   = 8'h00;
              status_nxt     = irq_calc(status_r & 8'hf9, timer_ctrl_r, s0_value_r);
            end
            if (s0_value_r[5] && s0_value_r[4]) begin
              cp2_out_nxt = s0_value_r[3];
            end
          end
          REG_DIR: begin
            if (!periph_ctrl_r[7]) begin
              dir_mask_nxt = s0_value_r;
            end
          end
          REG_PORT: begin
            if (!periph_ctrl_r[7]) begin
              port_latch_nxt = s0_value_r;
              status_nxt     = irq_calc(status_r & ~{5'b0, pend_clr_r[2:1], 1'b0},
                                        timer_ctrl_r, periph_ctrl_r);
              pend_clr_nxt   = {2'b00, pend_clr_r[0]};
            end
          end
          REG_TIMER_CTRL: begin
            timer_ctrl_nxt = s0_value_r;
            if (s0_value_r[0]) begin
              preset_nxt  = reload_r;
              status_nxt  = {status_r[7:1], 1'b0};
              if (s0_value_r[5:3] != MODE_CASCADE) begin
                raw_tout_nxt = 1'b0;
              end
              running_nxt = 1'b0;
              ticks_nxt   = '0;
              pulse_nxt   = '0;
            end else if (!running_r) begin
              do_launch = 1'b1;
            end
            status_nxt = irq_calc(status_nxt, s0_value_r, periph_ctrl_r);
          end
          REG_CNT_HIGH: high_buf_nxt = s0_value_r;
          REG_CNT_LOW: begin
            reload_nxt = {high_buf_r, s0_value_r};
            if (timer_ctrl_r[5:3] == MODE_CONT_A) begin
              preset_nxt   = {high_buf_r, s0_value_r};
              status_nxt   = irq_calc({status_r[7:1], 1'b0}, timer_ctrl_r, periph_ctrl_r);
              raw_tout_nxt = 1'b0;
              do_launch    = !timer_ctrl_r[0];
            end
          end
          default: ;
        endcase
      end
      CMD_TICK: begin
        if (pulse_r != '0) begin
          pulse_nxt = pulse_r - PULSE_W'(1);
          if (pulse_r == PULSE_W'(1)) begin
            raw_tout_nxt = 1'b1;
          end
        end
        if (running_r && ticks_r != '0) begin
          ticks_nxt = ticks_r - TICK_W'(1);
          do_expire = (ticks_r == TICK_W'(1));
        end
      end
      CMD_CP1: begin
        if (lv != cp1_level_r) begin
          cp1_level_nxt = lv;
          if (lv == periph_ctrl_r[1]) begin
            status_nxt = irq_calc(status_r | 8'h02, timer_ctrl_r, periph_ctrl_r);
          end
        end
      end
      CMD_CP2: begin
        if (lv != cp2_level_r) begin
          cp2_level_nxt = lv;
          if (!periph_ctrl_r[5] && lv == periph_ctrl_r[4]) begin
            status_nxt = irq_calc(status_r | 8'h04, timer_ctrl_r, periph_ctrl_r);
          end
        end
      end
      default: ;
    endcase

    // Timer start and period end, applied after the command's own updates.
    mode = timer_ctrl_nxt[5:3];
    if (do_launch) begin
      if (!mode[0]) begin
        raw_tout_nxt = (mode == MODE_CASCADE) ? raw_tout_nxt : 1'b0;
        if (mode == MODE_SINGLE) begin
          pulse_nxt = timer_ctrl_nxt[2] ? PULSE_W'(8) : PULSE_W'(1);
        end
        ticks_nxt   = ticks_calc(preset_nxt, timer_ctrl_nxt[2]);
        running_nxt = 1'b1;
        status_nxt  = irq_calc({status_nxt[7:1], 1'b0}, timer_ctrl_nxt, periph_ctrl_nxt);
      end else begin
        running_nxt = 1'b0;
        ticks_nxt   = '0;
      end
    end
    if (do_expire) begin
      preset_nxt = reload_r;
      if (!mode[0]) begin
        unique case (mode)
          MODE_CONT_A, MODE_CONT_B: raw_tout_nxt = ~raw_tout_nxt;
          MODE_SINGLE:              raw_tout_nxt = 1'b0;
          default:                  raw_tout_nxt = timer_ctrl_r[7];
        endcase
        ticks_nxt  = ticks_calc(reload_r, timer_ctrl_r[2]);
        status_nxt = irq_calc({status_nxt[7:1], 1'b1}, timer_ctrl_r, periph_ctrl_r);
      end else begin
        running_nxt = 1'b0;
        ticks_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      status_r      <= 8'h00;
      periph_ctrl_r <= 8'h80;
      dir_mask_r    <= 8'h00;
      port_latch_r  <= 8'h00;
      timer_ctrl_r  <= 8'h01;
      cp1_level_r   <= 1'b0;
      cp2_level_r   <= 1'b0;
      cp2_out_r     <= 1'b0;
      raw_tout_r    <= 1'b0;
      running_r     <= 1'b0;
      high_buf_r    <= 8'h00;
      pend_clr_r    <= 3'b000;
      reload_r      <= 16'hffff;
      preset_r      <= 16'hffff;
      ticks_r       <= '0;
      pulse_r       <= '0;
    end else begin
      if (in_ready) begin
        s0_valid_r <= in_valid;
      end
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (move) begin
        status_r      <= status_nxt;
        periph_ctrl_r <= periph_ctrl_nxt;
        dir_mask_r    <= dir_mask_nxt;
        port_latch_r  <= port_latch_nxt;
        timer_ctrl_r  <= timer_ctrl_nxt;
        cp1_level_r   <= cp1_level_nxt;
        cp2_level_r   <= cp2_level_nxt;
        cp2_out_r     <= cp2_out_nxt;
        raw_tout_r    <= raw_tout_nxt;
        running_r     <= running_nxt;
        high_buf_r    <= high_buf_nxt;
        pend_clr_r    <= pend_clr_nxt;
        reload_r      <= reload_nxt;
        preset_r      <= preset_nxt;
        ticks_r       <= ticks_nxt;
        pulse_r       <= pulse_nxt;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s0_cmd_r   <= in_cmd;
      s0_addr_r  <= in_reg_addr;
      s0_value_r <= in_value;
      s0_pins_r  <= in_pins_in;
    end
    if (move) begin
      rd_r    <= rd_nxt;
      irq_r   <= status_nxt[7];
      tout_r  <= ((timer_ctrl_nxt[5:3] == MODE_CASCADE) || timer_ctrl_nxt[7]) & raw_tout_nxt;
      drive_r <= port_latch_nxt & dir_mask_nxt;
      cp2_r   <= cp2_out_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = rd_r;
  assign out_irq_out    = irq_r;
  assign out_timer_out  = tout_r;
  assign out_port_drive = drive_r;
  assign out_cp2_drive  = cp2_r;

endmodule

>>> hw/rtl/ptio_checker.sv
// Port-level checker for the programmable timer and I/O port, with its bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module ptio_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_read_data,
  input logic [7:0] out_port_drive
);

  // No result is offered right after reset.
  `ASSERT_AFTER_RESET(a_no_out_after_reset, !out_valid)

  // A result side that takes transfers never stalls the input side.
  `ASSERT_IMPL(a_ready_when_drained, out_ready, in_ready)

  // An empty result register always leaves room for a new transfer.
  `ASSERT_IMPL(a_ready_when_empty, !out_valid, in_ready)

  // A stalled result stays offered with the same read data and port drive.
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
               out_valid && $stable(out_read_data) && $stable(out_port_drive))

endmodule

bind programmable_timer_io_port ptio_checker u_ptio_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_read_data  (out_read_data),
  .out_port_drive (out_port_drive)
);

>>> tb/testbench.sv
// Self-checking testbench for the programmable timer and I/O port.
// Depends on ptio_pkg and the programmable_timer_io_port RTL; a class predicts each result
// and checks it as it comes out; a task drives the input side, an initial block out_ready.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ptio_pkg::*;

  // Highest command code; codes above CMD_CP2 are unused and must change nothing.
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
    logic       timer;
    logic [7:0] port_drive;
    logic       cp2;
  } ptio_result_t;

  class port_timer_checker;
    ptio_result_t expected_outputs[$];
    int mismatches, results_seen, reads, writes, ticks, line_events, expiries;

    logic [7:0]  status_q, periph_q, dir_q, port_q, tctrl_q, high_buf_q;
    logic        cp1_q, cp2_q, cp2_out_q, raw_tmr_q, run_q;
    logic [2:0]  clear_arm_q;
    logic [15:0] latch_q, preset_q;
    logic [19:0] ticks_q;
    logic [3:0]  pulse_q;

    function new();
      mismatches = 0; results_seen = 0; reads = 0; writes = 0;
      ticks = 0; line_events = 0; expiries = 0;
      status_q = 8'h00; periph_q = 8'h80; dir_q = 8'h00; port_q = 8'h00;
      tctrl_q = 8'h01; high_buf_q = 8'h00;
      cp1_q = 1'b0; cp2_q = 1'b0; cp2_out_q = 1'b0; raw_tmr_q = 1'b0; run_q = 1'b0;
      clear_arm_q = 3'b000;
      latch_q = 16'hffff; preset_q = 16'hffff;
      ticks_q = '0; pulse_q = '0;
    endfunction

    function int unsigned div_factor();
      return tctrl_q[2] ? 8 : 1;
    endfunction

    function void refresh_irq();
      status_q[7] = (status_q[0] & tctrl_q[6]) | (status_q[1] & periph_q[0]) |
                    (status_q[2] & periph_q[3] & ~periph_q[5]);
    endfunction

    function void launch_timer();
      logic [2:0] mode;
      mode = tctrl_q[5:3];
      if (mode == MODE_CONT_A || mode == MODE_CONT_B) begin
        raw_tmr_q = 1'b0;
      end else if (mode == MODE_SINGLE) begin
        raw_tmr_q = 1'b0;
        pulse_q = 4'(div_factor());
      end else if (mode != MODE_CASCADE) begin
        // Unsupported modes just stop the counter.
        run_q = 1'b0;
        ticks_q = '0;
        return;
      end
      ticks_q = 20'(div_factor() * (32'(preset_q) + 32'd1));
      run_q = 1'b1;
      status_q[0] = 1'b0;
      refresh_irq();
    endfunction

    function void expire_timer();
      logic [2:0] mode;
      mode = tctrl_q[5:3];
      expiries++;
      preset_q = latch_q;
      if (mode == MODE_CONT_A || mode == MODE_CONT_B) begin
        raw_tmr_q = ~raw_tmr_q;
      end else if (mode == MODE_SINGLE) begin
        raw_tmr_q = 1'b0;
      end else if (mode == MODE_CASCADE) begin
        raw_tmr_q = tctrl_q[7];
      end else begin
        run_q = 1'b0;
        ticks_q = '0;
        return;
      end
      ticks_q = 20'(div_factor() * (32'(latch_q) + 32'd1));
      status_q[0] = 1'b1;
      refresh_irq();
    endfunction

    function logic [15:0] counter_now();
      if (run_q) return 16'(32'(ticks_q) / div_factor());
      return preset_q;
    endfunction

    function logic [7:0] bus_read(logic [2:0] addr, logic [7:0] pins);
      logic [15:0] cnt;
      case (addr)
        REG_STATUS, REG_STATUS_ALT: begin
          // Reading the status arms the flags that are set for clearing.
          clear_arm_q = status_q[2:0];
          return status_q;
        end
        REG_PERIPH:     return periph_q;
        REG_DIR:        return dir_q;
        REG_TIMER_CTRL: return tctrl_q;
        REG_PORT: begin
          if (!periph_q[7]) begin
            status_q[2:1] = status_q[2:1] & ~clear_arm_q[2:1];
            refresh_irq();
            clear_arm_q[2:1] = 2'b00;
          end
          return (port_q & dir_q) | (pins & ~dir_q);
        end
        default: begin
          if (clear_arm_q[0]) begin
            status_q[0] = 1'b0;
            refresh_irq();
          end
          clear_arm_q[0] = 1'b0;
          cnt = counter_now();
          return (addr == REG_CNT_HIGH) ? cnt[15:8] : cnt[7:0];
        end
      endcase
    endfunction

    function void bus_write(logic [2:0] addr, logic [7:0] d);
      case (addr)
        REG_PERIPH: begin
          periph_q = d;
          if (d[7]) begin
            port_q = 8'h00;
            dir_q = 8'h00;
            status_q[2:1] = 2'b00;
            refresh_irq();
          end
          if (d[5] && d[4]) cp2_out_q = d[3];
        end
        REG_DIR: if (!periph_q[7]) dir_q = d;
        REG_PORT: begin
          if (!periph_q[7]) begin
            port_q = d;
            status_q[2:1] = status_q[2:1] & ~clear_arm_q[2:1];
            clear_arm_q[2:1] = 2'b00;
            refresh_irq();
          end
        end
        REG_TIMER_CTRL: begin
          tctrl_q = d;
          if (d[0]) begin
            preset_q = latch_q;
            status_q[0] = 1'b0;
            if (tctrl_q[5:3] != MODE_CASCADE) raw_tmr_q = 1'b0;
            run_q = 1'b0;
            ticks_q = '0;
            pulse_q = '0;
          end else if (!run_q) begin
            launch_timer();
          end
          refresh_irq();
        end
        REG_CNT_HIGH: high_buf_q = d;
        REG_CNT_LOW: begin
          latch_q = {high_buf_q, d};
          if (tctrl_q[5:3] == MODE_CONT_A) begin
            preset_q = latch_q;
            status_q[0] = 1'b0;
            refresh_irq();
            raw_tmr_q = 1'b0;
            if (!tctrl_q[0]) launch_timer();
          end
        end
        default: ;
      endcase
    endfunction

    function void tick_once();
      // The single-shot pulse ends before a count expiry on the same tick.
      if (pulse_q != 0) begin
        pulse_q = pulse_q - 4'd1;
        if (pulse_q == 0) raw_tmr_q = 1'b1;
      end
      if (run_q && ticks_q != 0) begin
        ticks_q = ticks_q - 20'd1;
        if (ticks_q == 0) expire_timer();
      end
    endfunction

    function ptio_result_t predict_outputs(logic [2:0] cmd, logic [2:0] addr,
                                           logic [7:0] val, logic [7:0] pins);
      ptio_result_t r;
      logic lv;
      r = '0;
      lv = (val != 8'h00);
      case (cmd)
        CMD_READ:  begin reads++; r.read_data = bus_read(addr, pins); end
        CMD_WRITE: begin writes++; bus_write(addr, val); end
        CMD_TICK:  begin ticks++; tick_once(); end
        CMD_CP1: begin
          line_events++;
          if (lv != cp1_q) begin
            cp1_q = lv;
            if (lv == periph_q[1]) begin
              status_q[1] = 1'b1;
              refresh_irq();
            end
          end
        end
        CMD_CP2: begin
          line_events++;
          if (lv != cp2_q) begin
            cp2_q = lv;
            if (!periph_q[5] && lv == periph_q[4]) begin
              status_q[2] = 1'b1;
              refresh_irq();
            end
          end
        end
        default: ;
      endcase
      r.irq = status_q[7];
      r.timer = (tctrl_q[5:3] == MODE_CASCADE || tctrl_q[7]) ? raw_tmr_q : 1'b0;
      r.port_drive = port_q & dir_q;
      r.cp2 = cp2_out_q;
      return r;
    endfunction

    function void note_transfer(logic [2:0] cmd, logic [2:0] addr,
                                logic [7:0] val, logic [7:0] pins);
      expected_outputs.push_back(predict_outputs(cmd, addr, val, pins));
    endfunction

    task report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      mismatches++;
      $display("MISMATCH at %0t: %s got %0h expected %0h", $time, what, got, want);
    endtask

    task check_output(ptio_result_t got);
      ptio_result_t want;
      results_seen++;
      if (expected_outputs.size() == 0) begin
        report_mismatch("result with nothing pending", got.read_data, 8'h00);
      end else begin
        want = expected_outputs.pop_front();
        if (got.read_data !== want.read_data)
          report_mismatch("read_data", got.read_data, want.read_data);
        if (got.irq !== want.irq)
          report_mismatch("irq_out", {7'd0, got.irq}, {7'd0, want.irq});
        if (got.timer !== want.timer)
          report_mismatch("timer_out", {7'd0, got.timer}, {7'd0, want.timer});
        if (got.port_drive !== want.port_drive)
          report_mismatch("port_drive", got.port_drive, want.port_drive);
        if (got.cp2 !== want.cp2)
          report_mismatch("cp2_drive", {7'd0, got.cp2}, {7'd0, want.cp2});
      end
    endtask

    task drain_check();
      if (expected_outputs.size() != 0)
        report_mismatch("results never delivered", 8'(expected_outputs.size()), 8'h00);
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid, in_ready;
  logic [2:0] in_cmd, in_reg_addr;
  logic [7:0] in_value, in_pins_in;
  logic       out_valid, out_ready;
  logic [7:0] out_read_data, out_port_drive;
  logic       out_irq_out, out_timer_out, out_cp2_drive;

  port_timer_checker tracker;
  bit steady_flow = 1'b0;
  bit hold_off_go = 1'b0;

  programmable_timer_io_port u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_reg_addr    (in_reg_addr),
    .in_value       (in_value),
    .in_pins_in     (in_pins_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_data  (out_read_data),
    .out_irq_out    (out_irq_out),
    .out_timer_out  (out_timer_out),
    .out_port_drive (out_port_drive),
    .out_cp2_drive  (out_cp2_drive)
  );

  always #5 clk = ~clk;

  // Offer one item and return at the edge where it transfers.
  task automatic send_item(input logic [2:0] cmd, input logic [2:0] addr,
                           input logic [7:0] val, input logic [7:0] pins);
    while (!steady_flow && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_cmd      <= cmd;
    in_reg_addr <= addr;
    in_value    <= val;
    in_pins_in  <= pins;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_transfer(cmd, addr, val, pins);
  endtask

  // Mostly well-formed register traffic and ticks, with small counts so the timer
  // expires often, plus some unused commands and reset-mode writes as noise.
  task automatic send_random_item();
    logic [2:0] cmd, addr;
    logic [7:0] val, pins;
    int pick;
    pick = $urandom_range(99);
    addr = 3'($urandom_range(7));
    val  = 8'($urandom);
    pins = 8'($urandom);
    if (pick < 34) begin
      cmd = CMD_TICK;
    end else if (pick < 58) begin
      cmd = CMD_READ;
    end else if (pick < 86) begin
      cmd = CMD_WRITE;
      pick = $urandom_range(99);
      if (pick < 12) begin
        addr = REG_PERIPH;
        if ($urandom_range(99) < 85) val[7] = 1'b0;
      end else if (pick < 24) begin
        addr = REG_DIR;
      end else if (pick < 40) begin
        addr = REG_PORT;
      end else if (pick < 45) begin
        addr = ($urandom_range(1) != 0) ? REG_STATUS : REG_STATUS_ALT;
      end else if (pick < 65) begin
        addr = REG_TIMER_CTRL;
        if ($urandom_range(99) < 70) val[0] = 1'b0;
        if ($urandom_range(4) != 0) val[3] = 1'b0;
      end else if (pick < 80) begin
        addr = REG_CNT_HIGH;
        if ($urandom_range(99) < 80) val = 8'h00;
      end else begin
        addr = REG_CNT_LOW;
        if ($urandom_range(99) < 70) val = 8'($urandom_range(12));
      end
    end else if (pick < 98) begin
      cmd = (pick < 92) ? CMD_CP1 : CMD_CP2;
      if ($urandom_range(1) != 0) val = 8'h00;
    end else begin
      cmd = 3'($urandom_range(CMD_UNUSED_HI, CMD_CP2 + 3'd1));
    end
    send_item(cmd, addr, val, pins);
  endtask

  initial begin : stimulus
    int n;
    int drain_wait;
    tracker = new();
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_cmd      <= CMD_READ;
    in_reg_addr <= REG_STATUS;
    in_value    <= 8'h00;
    in_pins_in  <= 8'h00;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_item(CMD_READ,  REG_STATUS,     8'h00, 8'hff);
    send_item(CMD_WRITE, REG_STATUS_ALT, 8'hff, 8'h00);  // status is read-only
    send_item(CMD_WRITE, REG_DIR,        8'hff, 8'h00);  // held off by port reset
    send_item(CMD_WRITE, REG_PERIPH,     8'h1b, 8'h00);
    send_item(CMD_WRITE, REG_DIR,        8'hf0, 8'h00);
    send_item(CMD_WRITE, REG_PORT,       8'hff, 8'h00);
    send_item(CMD_CP1,   REG_STATUS,     8'h01, 8'h00);
    send_item(CMD_CP2,   REG_STATUS,     8'hff, 8'h00);
    send_item(CMD_CP2,   REG_STATUS,     8'h01, 8'h00);  // same level, no edge
    send_item(CMD_READ,  REG_STATUS_ALT, 8'h00, 8'h00);
    send_item(CMD_READ,  REG_PORT,       8'h00, 8'h5a);
    send_item(CMD_WRITE, REG_CNT_HIGH,   8'h00, 8'h00);
    send_item(CMD_WRITE, REG_CNT_LOW,    8'h01, 8'h00);
    send_item(CMD_WRITE, REG_TIMER_CTRL, 8'h42, 8'h00);
    send_item(CMD_TICK,  REG_STATUS,     8'h00, 8'h00);
    send_item(CMD_TICK,  REG_STATUS,     8'h00, 8'h00);
    send_item(CMD_READ,  REG_STATUS,     8'h00, 8'h00);
    send_item(CMD_READ,  REG_CNT_HIGH,   8'h00, 8'h00);
    send_item(CMD_WRITE, REG_TIMER_CTRL, 8'h01, 8'h00);
    send_item(CMD_WRITE, REG_CNT_LOW,    8'h00, 8'h00);
    // Single shot with a one-tick count: pulse end and expiry land on one tick.
    send_item(CMD_WRITE, REG_TIMER_CTRL, 8'ha0, 8'h00);
    send_item(CMD_TICK,  REG_STATUS,     8'h00, 8'h00);
    send_item(CMD_WRITE, REG_TIMER_CTRL, 8'h38, 8'h00);
    send_item(CMD_TICK,  REG_STATUS,     8'h00, 8'h00);
    send_item(CMD_WRITE, REG_TIMER_CTRL, 8'h08, 8'h00);
    send_item(CMD_READ,  REG_CNT_LOW,    8'h00, 8'h00);
    send_item(CMD_WRITE, REG_PERIPH,     8'h38, 8'h00);
    send_item(CMD_UNUSED_HI, REG_CNT_LOW, 8'hff, 8'hff);

    for (n = 0; n < 1000; n++) begin
      steady_flow = (n >= 300 && n < 450);
      if (n == 600) hold_off_go = 1'b1;
      send_random_item();
    end
    in_valid <= 1'b0;

    drain_wait = 0;
    while (tracker.expected_outputs.size() != 0 && drain_wait < 5000) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (8) @(posedge clk);
    tracker.drain_check();

    $display("Covered %0d reads, %0d writes, %0d ticks and %0d line events; %0d expiries.",
             tracker.reads, tracker.writes, tracker.ticks, tracker.line_events,
             tracker.expiries);
    $display("Checked %0d results, %0d mismatches.", tracker.results_seen,
             tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Result side: random stalls, plus one long hold-off so the block fills up.
  initial begin : result_sink
    int hold_left;
    bit hold_served;
    hold_left = 0;
    hold_served = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_go && !hold_served) begin
        hold_served = 1'b1;
        hold_left = 100;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady_flow || ($urandom_range(99) >= 13);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
      tracker.check_output({out_read_data, out_irq_out, out_timer_out,
                            out_port_drive, out_cp2_drive});
  end

  initial begin : watchdog
    #3_000_000;
    $display("Timeout: the block stopped making progress");
    $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> programmable_timer_io_port.f
+incdir+hw/rtl
hw/rtl/ptio_pkg.sv
hw/rtl/programmable_timer_io_port.sv
hw/rtl/ptio_checker.sv
tb/testbench.sv
